// ----- rtl/lei_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package lei_pkg;

  typedef enum logic [2:0] {
    ALU_Q,
    ALU_SUB,
    ALU_QSUB,
    ALU_CSUBQ,
    ALU_QADD
  } alu_op_t;

  typedef struct packed {
    alu_op_t            op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    logic signed [31:0] c;
  } alu_req_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               clip;
  } alu_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ALU,
    ST_DONE
  } seq_state_t;

  localparam int unsigned NUM_OPS = 12;
  localparam int unsigned OP_CNT_W = 4;
  localparam logic [OP_CNT_W-1:0] LAST_OP = OP_CNT_W'(NUM_OPS - 1);

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_SIGMA = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RHO   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BETA  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd4;

  localparam int unsigned GAIN_W = 31;
  localparam int unsigned COORD_W = 32;

endpackage

`default_nettype wire

// ----- rtl/lei_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none

module lei_alu #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic               clk,
  input  wire logic               issue,
  input  wire lei_pkg::alu_req_t  req,
  output lei_pkg::alu_rsp_t       rsp
);

  localparam logic signed [63:0] HALF   = 64'sd1 <<< (FRAC_BITS - 1);
  localparam logic signed [63:0] MAX64  = 64'sd2147483647;
  localparam logic signed [63:0] MIN64  = -64'sd2147483648;

  logic signed [63:0] prod_r;
  logic signed [31:0] a_r;
  logic signed [31:0] b_r;
  logic signed [31:0] c_r;
  lei_pkg::alu_op_t   op_r;

  always_ff @(posedge clk) begin
    if (issue) begin
      prod_r <= 64'(req.a) * 64'(req.b);
      a_r    <= req.a;
      b_r    <= req.b;
      c_r    <= req.c;
      op_r   <= req.op;
    end
  end

  logic signed [63:0] rnd;
  logic signed [63:0] shd;
  logic signed [31:0] q;
  logic               q_clip;
  logic signed [32:0] sum;
  logic               sum_clip;

  always_comb begin
    rnd    = prod_r + HALF;
    shd    = rnd >>> FRAC_BITS;
    q_clip = (shd > MAX64) || (shd < MIN64);
    if (shd > MAX64) begin
      q = 32'sh7fffffff;
    end else if (shd < MIN64) begin
      q = 32'sh80000000;
    end else begin
      q = shd[31:0];
    end
    case (op_r)
      lei_pkg::ALU_SUB:   sum = 33'(a_r) - 33'(b_r);
      lei_pkg::ALU_QSUB:  sum = 33'(q) - 33'(c_r);
      lei_pkg::ALU_CSUBQ: sum = 33'(c_r) - 33'(q);
      lei_pkg::ALU_QADD:  sum = 33'(c_r) + 33'(q);
      default:            sum = 33'(q);
    endcase
    sum_clip = sum[32] != sum[31];
    if (!sum_clip) begin
      rsp.value = sum[31:0];
    end else if (sum[32]) begin
      rsp.value = 32'sh80000000;
    end else begin
      rsp.value = 32'sh7fffffff;
    end
    rsp.clip = sum_clip || ((op_r != lei_pkg::ALU_SUB) && q_clip);
  end

endmodule

`default_nettype wire

// ----- rtl/lorenz_euler_integrator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One forward-Euler step of the Lorenz system per input item. A single
// 32x32 multiplier with round, saturate and add/subtract runs twelve
// operations in turn, each in a multiply state and an ALU state, then a
// done state moves the result into the output register. The next item can
// be taken in the cycle after that load. A result that is not taken holds
// off the load of the next one, and the input with it. No new item is taken
// while a step runs, since the shared multiplier and its post-add stage
// serve all twelve operations. Coordinates and results are signed fixed
// point with FRAC_BITS fraction bits; any clip to the 32-bit range during a
// step sets the saturated flag.

module lorenz_euler_integrator_top #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_tvalid,
  output logic                                      in_tready,
  input  wire logic [7:0]                           in_tdata,   // restart
  output logic                                      out_tvalid,
  input  wire logic                                 out_tready,
  output logic [95:0]                               out_tdata,  // x_scaled, y_scaled, z_scaled
  output logic [0:0]                                out_tuser,  // saturated
  input  wire logic                                 cfg_we,
  input  wire logic [lei_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire logic [lei_pkg::GAIN_W-1:0]           cfg_wdata
);

  localparam logic [63:0] Q_ONE64 = 64'd1 << FRAC_BITS;
  localparam logic signed [31:0] Q_ONE = 32'(Q_ONE64);
  localparam logic [30:0] SIGMA_RST = 31'(10 * Q_ONE64);
  localparam logic [30:0] RHO_RST   = 31'(28 * Q_ONE64);
  localparam logic [30:0] BETA_RST  = 31'((16 * Q_ONE64 + 3) / 6);
  localparam logic [30:0] DT_RST    = 31'((Q_ONE64 + 500) / 1000);
  localparam logic [30:0] SCALE_RST = 31'((4 * Q_ONE64 + 50) / 100);

  logic [30:0] sigma_r, rho_r, beta_r, dt_r, scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sigma_r <= SIGMA_RST;
      rho_r   <= RHO_RST;
      beta_r  <= BETA_RST;
      dt_r    <= DT_RST;
      scale_r <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lei_pkg::REG_SIGMA: sigma_r <= cfg_wdata;
        lei_pkg::REG_RHO:   rho_r   <= cfg_wdata;
        lei_pkg::REG_BETA:  beta_r  <= cfg_wdata;
        lei_pkg::REG_DT:    dt_r    <= cfg_wdata;
        lei_pkg::REG_SCALE: scale_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lei_pkg::seq_state_t state_r, state_nxt;
  logic [lei_pkg::OP_CNT_W-1:0] op_cnt_r;
  logic signed [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic signed [31:0] tmp_r, dx_r, dy_r, ox_r, oy_r;
  logic               sat_r;
  logic               out_tvalid_r;

  logic              in_acc;
  logic              issue;
  logic              load_out;
  lei_pkg::alu_req_t req;
  lei_pkg::alu_rsp_t rsp;

  assign in_acc   = in_tvalid && in_tready;
  assign issue    = state_r == lei_pkg::ST_MUL;
  assign load_out = (state_r == lei_pkg::ST_DONE) && (!out_tvalid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      lei_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) state_nxt = lei_pkg::ST_MUL;
      end
      lei_pkg::ST_MUL: state_nxt = lei_pkg::ST_ALU;
      lei_pkg::ST_ALU: begin
        if (op_cnt_r == lei_pkg::LAST_OP) state_nxt = lei_pkg::ST_DONE;
        else state_nxt = lei_pkg::ST_MUL;
      end
      lei_pkg::ST_DONE: begin
        if (load_out) state_nxt = lei_pkg::ST_IDLE;
      end
      default: state_nxt = lei_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lei_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    req.op = lei_pkg::ALU_Q;
    req.a  = pos_x_r;
    req.b  = pos_y_r;
    req.c  = tmp_r;
    case (op_cnt_r)
      4'd0: begin
        req.op = lei_pkg::ALU_SUB;
        req.a  = pos_y_r;
        req.b  = pos_x_r;
      end
      4'd1: begin
        req.a = $signed({1'b0, sigma_r});
        req.b = tmp_r;
      end
      4'd2: begin
        req.op = lei_pkg::ALU_SUB;
        req.a  = $signed({1'b0, rho_r});
        req.b  = pos_z_r;
      end
      4'd3: begin
        req.op = lei_pkg::ALU_QSUB;
        req.b  = tmp_r;
        req.c  = pos_y_r;
      end
      4'd4: ;
      4'd5: begin
        req.op = lei_pkg::ALU_CSUBQ;
        req.a  = $signed({1'b0, beta_r});
        req.b  = pos_z_r;
      end
      4'd6: begin
        req.op = lei_pkg::ALU_QADD;
        req.a  = dx_r;
        req.b  = $signed({1'b0, dt_r});
        req.c  = pos_x_r;
      end
      4'd7: begin
        req.op = lei_pkg::ALU_QADD;
        req.a  = dy_r;
        req.b  = $signed({1'b0, dt_r});
        req.c  = pos_y_r;
      end
      4'd8: begin
        req.op = lei_pkg::ALU_QADD;
        req.a  = tmp_r;
        req.b  = $signed({1'b0, dt_r});
        req.c  = pos_z_r;
      end
      4'd9: req.b = $signed({1'b0, scale_r});
      4'd10: begin
        req.a = pos_y_r;
        req.b = $signed({1'b0, scale_r});
      end
      default: begin
        req.a = pos_z_r;
        req.b = $signed({1'b0, scale_r});
      end
    endcase
  end

  lei_alu #(
    .FRAC_BITS (FRAC_BITS)
  ) u_alu (
    .clk   (clk),
    .issue (issue),
    .req   (req),
    .rsp   (rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_cnt_r <= '0;
      sat_r    <= 1'b0;
      pos_x_r  <= Q_ONE;
      pos_y_r  <= Q_ONE;
      pos_z_r  <= Q_ONE;
    end else if (in_acc) begin
      op_cnt_r <= '0;
      sat_r    <= 1'b0;
      if (in_tdata[0]) begin
        pos_x_r <= Q_ONE;
        pos_y_r <= Q_ONE;
        pos_z_r <= Q_ONE;
      end
    end else if (state_r == lei_pkg::ST_ALU) begin
      sat_r <= sat_r | rsp.clip;
      if (op_cnt_r != lei_pkg::LAST_OP) op_cnt_r <= op_cnt_r + 1'b1;
      case (op_cnt_r)
        4'd6: pos_x_r <= rsp.value;
        4'd7: pos_y_r <= rsp.value;
        4'd8: pos_z_r <= rsp.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == lei_pkg::ST_ALU) begin
      case (op_cnt_r)
        4'd0, 4'd2, 4'd4, 4'd5: tmp_r <= rsp.value;
        4'd1:  dx_r <= rsp.value;
        4'd3:  dy_r <= rsp.value;
        4'd9:  ox_r <= rsp.value;
        4'd10: oy_r <= rsp.value;
        4'd11: tmp_r <= rsp.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_tdata <= {tmp_r, oy_r, ox_r};
      out_tuser <= sat_r;
    end
  end

  assign out_tvalid = out_tvalid_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_tready)
    else $error("input taken while a step is running");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |-> !load_out)
    else $error("pending result overwritten");

  a_op_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    op_cnt_r <= lei_pkg::LAST_OP)
    else $error("operation counter out of range");

  a_restart_load: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tdata[0]) |=> (pos_x_r == Q_ONE && pos_y_r == Q_ONE && pos_z_r == Q_ONE))
    else $error("restart did not reload the state");

endmodule

`default_nettype wire

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAC = 24;
  localparam longint Q_ONE = longint'(1) << FRAC;
  localparam longint Q_HALF = Q_ONE >>> 1;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;
  localparam logic [lei_pkg::GAIN_W-1:0] GAIN_MAX = 31'h7FFF_FFFF;
  localparam logic [lei_pkg::GAIN_W-1:0] DEF_SIGMA = 31'(10 * Q_ONE);
  localparam logic [lei_pkg::GAIN_W-1:0] DEF_RHO = 31'(28 * Q_ONE);
  localparam logic [lei_pkg::GAIN_W-1:0] DEF_BETA = 31'((16 * Q_ONE + 3) / 6);
  localparam logic [lei_pkg::GAIN_W-1:0] DEF_DT = 31'((Q_ONE + 500) / 1000);
  localparam logic [lei_pkg::GAIN_W-1:0] DEF_SCALE = 31'((4 * Q_ONE + 50) / 100);
  localparam logic [lei_pkg::GAIN_W-1:0] GAIN_ONE = 31'(Q_ONE);
  localparam logic [lei_pkg::CFG_IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [lei_pkg::CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int NUM_PHASES = 12;
  localparam int ITEMS_PER_PHASE = 95;
  localparam int IDLE_GAP = 4;
  localparam int LONG_HOLD = 300;
  localparam int TIMEOUT_NS = 3_000_000;
  localparam int N_ROWS = 39;

  typedef struct packed {
    logic signed [31:0] xs;
    logic signed [31:0] ys;
    logic signed [31:0] zs;
    logic               sat;
  } point_t;

  typedef enum logic {ROW_WRITE, ROW_STEP} row_kind_t;

  typedef struct packed {
    row_kind_t                       kind;
    logic [lei_pkg::CFG_IDX_W-1:0]   idx;
    logic [lei_pkg::GAIN_W-1:0]      wdata;
    logic                            restart;
    logic                            typed;
    point_t                          want;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [7:0]                    in_tdata = 8'd0;    // restart
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [95:0]                   out_tdata;          // x_scaled, y_scaled, z_scaled
  logic [0:0]                    out_tuser;          // saturated
  logic                          cfg_we = 1'b0;
  logic [lei_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [lei_pkg::GAIN_W-1:0]    cfg_wdata = '0;

  lorenz_euler_integrator_top #(.FRAC_BITS(FRAC)) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  point_t expected_points[$];
  int     failures = 0;
  int     steps_checked = 0;
  int     clipped_steps = 0;
  int     phases_run = 0;
  bit     quiet_flow = 1'b0;
  bit     hold_sink = 1'b0;
  bit     step_clip;

  longint g_sigma = longint'(DEF_SIGMA);
  longint g_rho = longint'(DEF_RHO);
  longint g_beta = longint'(DEF_BETA);
  longint g_dt = longint'(DEF_DT);
  longint g_scale = longint'(DEF_SCALE);
  longint coord_x = Q_ONE;
  longint coord_y = Q_ONE;
  longint coord_z = Q_ONE;

  function automatic longint clamp32(longint v);
    if (v > S32_MAX) begin
      step_clip = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      step_clip = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b;
    return clamp32((p + Q_HALF) >>> FRAC);
  endfunction

  function automatic point_t lorenz_advance(bit restart);
    longint x, y, z, dx, dy, dz, t1, t2;
    point_t r;
    step_clip = 1'b0;
    if (restart) begin
      coord_x = Q_ONE;
      coord_y = Q_ONE;
      coord_z = Q_ONE;
    end
    x = coord_x;
    y = coord_y;
    z = coord_z;
    dx = fx_mul(g_sigma, clamp32(y - x));
    t1 = fx_mul(x, clamp32(g_rho - z));
    dy = clamp32(t1 - y);
    t1 = fx_mul(x, y);
    t2 = fx_mul(g_beta, z);
    dz = clamp32(t1 - t2);
    coord_x = clamp32(x + fx_mul(dx, g_dt));
    coord_y = clamp32(y + fx_mul(dy, g_dt));
    coord_z = clamp32(z + fx_mul(dz, g_dt));
    r.xs = 32'(fx_mul(coord_x, g_scale));
    r.ys = 32'(fx_mul(coord_y, g_scale));
    r.zs = 32'(fx_mul(coord_z, g_scale));
    r.sat = step_clip;
    return r;
  endfunction

  function automatic row_t row_write(logic [lei_pkg::CFG_IDX_W-1:0] idx,
                                     logic [lei_pkg::GAIN_W-1:0] data);
    row_t r;
    r = '0;
    r.kind = ROW_WRITE;
    r.idx = idx;
    r.wdata = data;
    return r;
  endfunction

  function automatic row_t row_step(logic restart);
    row_t r;
    r = '0;
    r.kind = ROW_STEP;
    r.restart = restart;
    return r;
  endfunction

  function automatic row_t row_check(logic restart, longint ex, longint ey, longint ez,
                                     logic esat);
    row_t r;
    r = row_step(restart);
    r.typed = 1'b1;
    r.want.xs = 32'(ex);
    r.want.ys = 32'(ey);
    r.want.zs = 32'(ez);
    r.want.sat = esat;
    return r;
  endfunction

  function automatic logic [lei_pkg::GAIN_W-1:0] pick_gain(int unsigned typ_hi);
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 7) return lei_pkg::GAIN_W'($urandom_range(0, typ_hi));
    if (sel == 7) return lei_pkg::GAIN_W'($urandom);
    if (sel == 8) return '0;
    return GAIN_MAX;
  endfunction

  task automatic write_reg(logic [lei_pkg::CFG_IDX_W-1:0] idx,
                           logic [lei_pkg::GAIN_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      lei_pkg::REG_SIGMA: g_sigma = longint'(data);
      lei_pkg::REG_RHO:   g_rho = longint'(data);
      lei_pkg::REG_BETA:  g_beta = longint'(data);
      lei_pkg::REG_DT:    g_dt = longint'(data);
      lei_pkg::REG_SCALE: g_scale = longint'(data);
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // hold the input low until every expected step has come out
  task automatic drain_block();
    in_tvalid <= 1'b0;
    while (expected_points.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  task automatic send_step(bit restart, bit typed, point_t typed_val);
    point_t predicted;
    int     gap;
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, restart};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predicted = lorenz_advance(restart);
    expected_points.push_back(typed ? typed_val : predicted);
    gap = 0;
    if (!quiet_flow && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  initial begin : sink
    forever begin
      if (hold_sink) begin
        hold_sink = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_flow && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    point_t got;
    point_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.xs = out_tdata[31:0];
      got.ys = out_tdata[63:32];
      got.zs = out_tdata[95:64];
      got.sat = out_tuser[0];
      if (expected_points.size() == 0) begin
        $display("%0t: unexpected item x=%h y=%h z=%h sat=%b",
                 $time, got.xs, got.ys, got.zs, got.sat);
        failures++;
      end else begin
        want = expected_points.pop_front();
        steps_checked++;
        if (got.sat) clipped_steps++;
        if (got.xs !== want.xs || got.ys !== want.ys || got.zs !== want.zs ||
            got.sat !== want.sat) begin
          $display("%0t: mismatch expected x=%h y=%h z=%h sat=%b actual x=%h y=%h z=%h sat=%b",
                   $time, want.xs, want.ys, want.zs, want.sat,
                   got.xs, got.ys, got.zs, got.sat);
          failures++;
        end
      end
    end
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("lorenz_euler_integrator_top regression: fail");
    $finish;
  end

  initial begin : stimulus
    row_t directed_rows [0:N_ROWS-1];
    int   wait_cycles;
    directed_rows = '{
      row_step(1'b0),
      row_step(1'b0),
      row_step(1'b1),
      row_write(lei_pkg::REG_DT, '0),
      row_write(lei_pkg::REG_SCALE, GAIN_ONE),
      row_check(1'b1, Q_ONE, Q_ONE, Q_ONE, 1'b0),
      row_check(1'b0, Q_ONE, Q_ONE, Q_ONE, 1'b0),
      row_write(lei_pkg::REG_SCALE, '0),
      row_check(1'b0, 0, 0, 0, 1'b0),
      row_write(lei_pkg::REG_SIGMA, '0),
      row_write(lei_pkg::REG_RHO, '0),
      row_write(lei_pkg::REG_BETA, '0),
      row_write(lei_pkg::REG_DT, GAIN_ONE),
      row_write(lei_pkg::REG_SCALE, GAIN_ONE),
      row_check(1'b1, Q_ONE, -Q_ONE, 2 * Q_ONE, 1'b0),
      row_step(1'b0),
      row_write(lei_pkg::REG_SIGMA, GAIN_MAX),
      row_write(lei_pkg::REG_RHO, GAIN_MAX),
      row_write(lei_pkg::REG_BETA, GAIN_MAX),
      row_write(lei_pkg::REG_DT, GAIN_MAX),
      row_write(lei_pkg::REG_SCALE, GAIN_MAX),
      row_step(1'b1),
      row_step(1'b0),
      row_step(1'b0),
      row_write(REG_SPARE_LO, '0),
      row_write(REG_SPARE_HI, GAIN_MAX),
      row_step(1'b0),
      row_write(lei_pkg::REG_SIGMA, DEF_SIGMA),
      row_write(lei_pkg::REG_RHO, DEF_RHO),
      row_write(lei_pkg::REG_BETA, DEF_BETA),
      row_write(lei_pkg::REG_DT, GAIN_MAX),
      row_write(lei_pkg::REG_SCALE, GAIN_ONE),
      row_check(1'b1, Q_ONE, S32_MAX, S32_MIN + Q_ONE, 1'b1),
      row_check(1'b1, Q_ONE, S32_MAX, S32_MIN + Q_ONE, 1'b1),
      row_write(lei_pkg::REG_DT, DEF_DT),
      row_write(lei_pkg::REG_SCALE, DEF_SCALE),
      row_step(1'b1),
      row_step(1'b0),
      row_step(1'b0)
    };

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_WRITE) begin
        drain_block();
        write_reg(directed_rows[i].idx, directed_rows[i].wdata);
      end else begin
        send_step(directed_rows[i].restart, directed_rows[i].typed, directed_rows[i].want);
      end
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_block();
      phases_run++;
      quiet_flow = (ph >= NUM_PHASES - 2);
      write_reg(lei_pkg::REG_SIGMA, pick_gain(32'(20 * Q_ONE)));
      write_reg(lei_pkg::REG_RHO, pick_gain(32'(50 * Q_ONE)));
      write_reg(lei_pkg::REG_BETA, pick_gain(32'(4 * Q_ONE)));
      write_reg(lei_pkg::REG_DT, pick_gain(32'(Q_ONE / 20)));
      write_reg(lei_pkg::REG_SCALE, pick_gain(32'(2 * Q_ONE)));
      if ($urandom_range(0, 2) == 0)
        write_reg(lei_pkg::CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                  lei_pkg::GAIN_W'($urandom));
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (ph == 3 && k == 10) hold_sink = 1'b1;
        if (ph == 6 && k == 40) drain_block();
        send_step($urandom_range(0, 19) == 0, 1'b0, '0);
      end
    end
    in_tvalid <= 1'b0;

    wait_cycles = 0;
    while (expected_points.size() != 0 && wait_cycles < 5000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (30) @(posedge clk);
    if (expected_points.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_points.size());
      failures++;
    end

    $display("Checked %0d Euler steps over %0d random coefficient sets plus directed cases,",
             steps_checked, phases_run);
    $display("%0d of them with clipping; %0d mismatches.", clipped_steps, failures);
    if (failures == 0) begin
      $display("lorenz_euler_integrator_top regression: pass");
    end else begin
      $display("lorenz_euler_integrator_top regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/lei_pkg.sv
rtl/lei_alu.sv
rtl/lorenz_euler_integrator_top.sv
tb/sv/testbench.sv
